// ----- hw/rtl/camera_blob_stream_parser_top_defines.svh -----
`ifndef CAMERA_BLOB_STREAM_PARSER_TOP_DEFINES_SVH
`define CAMERA_BLOB_STREAM_PARSER_TOP_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define CBSP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cbsp_pkg.sv -----
`timescale 1ns / 1ps

package cbsp_pkg;

    localparam int MAX_BLOBS = 10;
    localparam int CNT_W     = $clog2(MAX_BLOBS + 1);
    localparam int ADDR_W    = $clog2(2 * MAX_BLOBS);
    localparam int IDX_W     = 4;

    localparam int WIN_SIZE  = 16;
    localparam int WIN_LEN_W = 5;
    localparam int BLOCK_LEN = 14;
    localparam int FRAME_LEN = 16;

    localparam logic [7:0] SYNC_A = 8'h55;
    localparam logic [7:0] SYNC_B = 8'hAA;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_INCOMPLETE = 3'd0,
        ST_INVALID    = 3'd1,
        ST_FRAME      = 3'd2,
        ST_BLOCK      = 3'd3,
        ST_READ       = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] blob;   // h, w, y, x from the top down
    } push_info_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] count;
    } bank_resp_t;

endpackage

// ----- hw/rtl/cbsp_window.sv -----
`timescale 1ns / 1ps

`include "camera_blob_stream_parser_top_defines.svh"

module cbsp_window
    import cbsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic [7:0] data_byte,
    output push_info_t push_info
);

    logic [7:0]           win_reg [WIN_SIZE];
    logic [7:0]           win_next[WIN_SIZE];
    logic [WIN_LEN_W-1:0] len_reg;
    logic [WIN_LEN_W-1:0] len_next;

    logic [7:0]           base[WIN_SIZE];
    logic [7:0]           app [WIN_SIZE];
    logic [3:0]           len_eff;
    logic [WIN_LEN_W-1:0] len_new;
    logic [15:0]          wd[WIN_SIZE/2];
    logic [15:0]          sum_block;
    logic [15:0]          sum_frame;
    status_t              status;

    always_comb begin
        // window already full: drop the oldest byte first
        if (len_reg >= WIN_LEN_W'(WIN_SIZE)) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                base[i] = (i < WIN_SIZE - 1) ? win_reg[(i + 1) % WIN_SIZE] : 8'h00;
            end
            len_eff = 4'(WIN_SIZE - 1);
        end else begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                base[i] = win_reg[i];
            end
            len_eff = len_reg[3:0];
        end
        for (int i = 0; i < WIN_SIZE; i++) begin
            app[i] = (len_eff == 4'(i)) ? data_byte : base[i];
        end
        len_new = {1'b0, len_eff} + WIN_LEN_W'(1);
        for (int k = 0; k < WIN_SIZE / 2; k++) begin
            wd[k] = {app[2*k+1], app[2*k]};
        end
        sum_block = wd[2] + wd[3] + wd[4] + wd[5] + wd[6];
        sum_frame = wd[3] + wd[4] + wd[5] + wd[6] + wd[7];
    end

    always_comb begin
        priority if (app[0] != SYNC_A) begin
            status = ST_INVALID;
        end else if (len_new >= WIN_LEN_W'(2) && app[1] != SYNC_B) begin
            status = ST_INVALID;
        end else if (len_new < WIN_LEN_W'(BLOCK_LEN)) begin
            status = ST_INCOMPLETE;
        end else if (app[2] == SYNC_A && app[3] == SYNC_B) begin
            if (len_new < WIN_LEN_W'(FRAME_LEN)) begin
                status = ST_INCOMPLETE;
            end else begin
                status = (wd[2] == sum_frame) ? ST_FRAME : ST_INVALID;
            end
        end else begin
            status = (wd[1] == sum_block) ? ST_BLOCK : ST_INVALID;
        end
    end

    always_comb begin
        push_info.status = status;
        if (status == ST_FRAME) begin
            push_info.blob = {wd[7], wd[6], wd[5], wd[4]};
        end else begin
            push_info.blob = {wd[6], wd[5], wd[4], wd[3]};
        end
    end

    always_comb begin
        unique case (status)
            ST_FRAME, ST_BLOCK: begin
                for (int i = 0; i < WIN_SIZE; i++) begin
                    win_next[i] = app[i];
                end
                len_next = '0;
            end
            ST_INVALID: begin
                for (int i = 0; i < WIN_SIZE; i++) begin
                    win_next[i] = (i < WIN_SIZE - 1) ? app[(i + 1) % WIN_SIZE] : 8'h00;
                end
                len_next = len_new - WIN_LEN_W'(1);
            end
            default: begin
                for (int i = 0; i < WIN_SIZE; i++) begin
                    win_next[i] = app[i];
                end
                len_next = len_new;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            for (int i = 0; i < WIN_SIZE; i++) begin
                win_reg[i] <= 8'h00;
            end
        end else if (push) begin
            len_reg <= len_next;
            for (int i = 0; i < WIN_SIZE; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    `CBSP_ASSERT_ALWAYS(a_len_below_full, len_reg < WIN_LEN_W'(WIN_SIZE), "window length reached 16")
    `CBSP_ASSERT_NEXT(a_block_clears_len, push && (status == ST_FRAME || status == ST_BLOCK), len_reg == '0, "length not cleared after block")

endmodule

// ----- hw/rtl/cbsp_bank.sv -----
`timescale 1ns / 1ps

`include "camera_blob_stream_parser_top_defines.svh"

module cbsp_bank
    import cbsp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  push_info_t       push_info,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_index,
    output bank_resp_t       resp,
    output logic [63:0]      rd_data
);

    logic [63:0]      mem[2 * MAX_BLOBS];
    logic [63:0]      rd_data_reg;

    logic [CNT_W-1:0] counts_reg [2];
    logic [CNT_W-1:0] counts_next[2];
    logic             write_bank_reg;
    logic             write_bank_next;

    logic [CNT_W-1:0] cnt_w;
    logic [CNT_W-1:0] cnt_w_after;
    logic             closes;
    logic             swap;
    logic             store;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic             found;

    always_comb begin
        cnt_w  = counts_reg[write_bank_reg];
        closes = (push_info.status == ST_FRAME) || (push_info.status == ST_INVALID);
        swap   = push && closes && (cnt_w != '0);
        write_bank_next = write_bank_reg ^ swap;
        cnt_w_after = swap ? '0 : cnt_w;
        store = push && ((push_info.status == ST_FRAME) || (push_info.status == ST_BLOCK))
                && (cnt_w_after < CNT_W'(MAX_BLOBS));
        wr_addr = ADDR_W'(cnt_w_after) + (write_bank_next ? ADDR_W'(MAX_BLOBS) : '0);

        // the bank that is not written keeps its count, also across a swap
        for (int b = 0; b < 2; b++) begin
            counts_next[b] = (1'(b) == write_bank_next) ? cnt_w_after + CNT_W'(store)
                                                         : counts_reg[b];
        end

        found = ({1'b0, rd_index} < (IDX_W+1)'(counts_reg[!write_bank_reg]))
                && ({1'b0, rd_index} < (IDX_W+1)'(MAX_BLOBS));
        rd_addr = ADDR_W'(rd_index) + (write_bank_reg ? '0 : ADDR_W'(MAX_BLOBS));

        resp.found = rd_en && found;
        resp.count = counts_next[!write_bank_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_bank_reg <= 1'b0;
            counts_reg[0]  <= '0;
            counts_reg[1]  <= '0;
        end else if (push) begin
            write_bank_reg <= write_bank_next;
            counts_reg[0]  <= counts_next[0];
            counts_reg[1]  <= counts_next[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            mem[wr_addr] <= push_info.blob;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en && found) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    `CBSP_ASSERT_ALWAYS(a_counts_bounded, counts_reg[0] <= CNT_W'(MAX_BLOBS) && counts_reg[1] <= CNT_W'(MAX_BLOBS), "bank count above capacity")
    `CBSP_ASSERT_NEXT(a_swap_fresh_bank, swap, counts_reg[write_bank_reg] <= CNT_W'(1), "new write bank not emptied")
    `CBSP_ASSERT_ALWAYS(a_push_read_excl, !(push && rd_en), "push and read in one cycle")

endmodule

// ----- hw/rtl/camera_blob_stream_parser_top.sv -----
// A result word is registered: it is valid on m_tvalid in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the single output register is refilled in the
// cycle it drains, so s_tready only drops while a result waits with m_tready low.
// Reset (aresetn low, synchronous): clears the byte window, bank counts, bank select
// and output valid; blob storage is not cleared and is only read where written.
`timescale 1ns / 1ps

`include "camera_blob_stream_parser_top_defines.svh"

module camera_blob_stream_parser_top
    import cbsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], blob_index[11:8], zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // blob_found[0], blob_x[16:1], blob_y[32:17],
                                   // blob_width[48:33], blob_height[64:49],
                                   // completed_count[68:65], zero pad
    output logic [2:0]  m_tuser    // status
);

    logic        accept;
    logic        push;
    logic        rd_en;
    push_info_t  push_info;
    bank_resp_t  resp;
    logic [63:0] rd_data;
    logic [63:0] blob_out;

    logic        m_valid_reg;
    status_t     status_reg;
    status_t     status_next;
    logic        found_reg;
    logic [3:0]  count_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (s_tuser == CMD_PUSH);
    assign rd_en    = accept && (s_tuser == CMD_READ);

    cbsp_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .data_byte (s_tdata[7:0]),
        .push_info (push_info)
    );

    cbsp_bank u_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_info (push_info),
        .rd_en     (rd_en),
        .rd_index  (s_tdata[11:8]),
        .resp      (resp),
        .rd_data   (rd_data)
    );

    assign status_next = (s_tuser == CMD_READ) ? ST_READ : push_info.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            found_reg  <= resp.found;
            count_reg  <= 4'(resp.count);
        end
    end

    assign blob_out = found_reg ? rd_data : 64'd0;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, count_reg, blob_out, found_reg};

    `CBSP_ASSERT_ALWAYS(a_found_only_on_read, !(m_valid_reg && found_reg) || status_reg == ST_READ, "blob found on a push result")

endmodule

// ----- bench/tb_camera_blob_stream_parser_top.sv -----
`timescale 1ns / 1ps

import cbsp_pkg::*;

typedef struct {
    status_t    status;
    bit         found;
    bit [15:0]  cx;
    bit [15:0]  cy;
    bit [15:0]  bw;
    bit [15:0]  bh;
    bit [3:0]   count;
} blob_result_t;

class blob_bank_tracker;
    bit [7:0]     window [WIN_SIZE];
    int unsigned  win_len;
    bit [63:0]    bank [2][MAX_BLOBS];
    int unsigned  bank_cnt [2];
    bit           wr_bank;
    blob_result_t pending_results [$];
    int unsigned  mismatches;

    function new();
        foreach (window[i]) window[i] = '0;
        win_len = 0;
        bank_cnt[0] = 0;
        bank_cnt[1] = 0;
        wr_bank = 1'b0;
        mismatches = 0;
    endfunction

    function bit [15:0] le_word(int unsigned pos);
        return {window[(pos + 1) % WIN_SIZE], window[pos % WIN_SIZE]};
    endfunction

    function bit [15:0] word_sum(int unsigned start);
        bit [15:0] s;
        s = '0;
        for (int k = 0; k < 5; k++) s += le_word(start + 2 * k);
        return s;
    endfunction

    function status_t classify();
        if (win_len == 0) return ST_INCOMPLETE;
        if (window[0] != SYNC_A) return ST_INVALID;
        if (win_len >= 2 && window[1] != SYNC_B) return ST_INVALID;
        if (win_len < BLOCK_LEN) return ST_INCOMPLETE;
        if (window[2] == SYNC_A && window[3] == SYNC_B) begin
            if (win_len < FRAME_LEN) return ST_INCOMPLETE;
            if (le_word(4) == word_sum(6)) return ST_FRAME;
            return ST_INVALID;
        end
        if (le_word(2) == word_sum(4)) return ST_BLOCK;
        return ST_INVALID;
    endfunction

    function void shift_out();
        if (win_len == 0) return;
        for (int i = 0; i < WIN_SIZE - 1; i++) window[i] = window[i + 1];
        window[WIN_SIZE - 1] = '0;
        win_len--;
    endfunction

    function void close_bank();
        wr_bank = ~wr_bank;
        bank_cnt[wr_bank] = 0;
    endfunction

    function void keep_blob(int unsigned start);
        if (bank_cnt[wr_bank] >= MAX_BLOBS) return;
        bank[wr_bank][bank_cnt[wr_bank]] =
            {le_word(start + 6), le_word(start + 4), le_word(start + 2), le_word(start)};
        bank_cnt[wr_bank]++;
    endfunction

    function void note_word(logic cmd, bit [7:0] data, bit [3:0] idx);
        blob_result_t r;
        bit [63:0]    blob;
        bit           rd;
        blob = '0;
        r.found = 1'b0;
        if (cmd == CMD_PUSH) begin
            if (win_len >= WIN_SIZE) begin
                win_len = WIN_SIZE;
                shift_out();
            end
            window[win_len % WIN_SIZE] = data;
            win_len++;
            r.status = classify();
            case (r.status)
                ST_FRAME: begin
                    win_len = 0;
                    if (bank_cnt[wr_bank] != 0) close_bank();
                    keep_blob(8);
                end
                ST_BLOCK: begin
                    win_len = 0;
                    keep_blob(6);
                end
                ST_INVALID: begin
                    shift_out();
                    if (bank_cnt[wr_bank] != 0) close_bank();
                end
                default: ;
            endcase
        end else begin
            r.status = ST_READ;
            rd = ~wr_bank;
            if (idx < bank_cnt[rd] && idx < MAX_BLOBS) begin
                r.found = 1'b1;
                blob = bank[rd][idx];
            end
        end
        {r.bh, r.bw, r.cy, r.cx} = blob;
        rd = ~wr_bank;
        r.count = 4'(bank_cnt[rd]);
        pending_results.push_back(r);
    endfunction

    function void check_word(logic [2:0] st, logic [71:0] data);
        blob_result_t e;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: status %0d data %h", st, data);
            return;
        end
        e = pending_results.pop_front();
        if (st !== e.status || data[0] !== e.found || data[16:1] !== e.cx ||
            data[32:17] !== e.cy || data[48:33] !== e.bw || data[64:49] !== e.bh ||
            data[68:65] !== e.count) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp: status %0d found %0d x %h y %h w %h h %h count %0d",
                         e.status, e.found, e.cx, e.cy, e.bw, e.bh, e.count);
                $display("         got: status %0d found %0d x %h y %h w %h h %h count %0d",
                         st, data[0], data[16:1], data[32:17], data[48:33], data[64:49],
                         data[68:65]);
            end
        end
    endfunction
endclass

module tb_camera_blob_stream_parser_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 750;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    blob_bank_tracker tracker = new();

    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    bit          long_hold_req = 1'b0;

    camera_blob_stream_parser_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata);
    end

    // receiver: changing stall patterns, plus one long hold on request
    initial begin
        int unsigned rx_mode;
        int unsigned rx_left;
        rx_mode = 0;
        rx_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(10, 80);
                end
                rx_left--;
                case (rx_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    2: m_tready = ($urandom_range(0, 7) != 0);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic cmd, input bit [7:0] data, input bit [3:0] idx);
        @(negedge aclk);
        s_tuser  = cmd;
        s_tdata  = {4'b0, idx, data};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(cmd, data, idx);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end
        end
    endtask

    task automatic push_byte(input bit [7:0] b);
        send_word(CMD_PUSH, b, 4'($urandom));
    endtask

    task automatic read_blob(input bit [3:0] idx);
        send_word(CMD_READ, 8'($urandom), idx);
    endtask

    task automatic send_packet(input bit is_frame, input bit [15:0] sig, input bit [15:0] x,
                               input bit [15:0] y, input bit [15:0] w, input bit [15:0] h,
                               input bit corrupt);
        bit [7:0]    pkt [16];
        bit [15:0]   vals [5];
        bit [15:0]   csum;
        int unsigned n;
        int unsigned base;
        int unsigned pos;
        vals = '{sig, x, y, w, h};
        csum = sig + x + y + w + h;
        pkt[0] = SYNC_A;
        pkt[1] = SYNC_B;
        if (is_frame) begin
            pkt[2] = SYNC_A;
            pkt[3] = SYNC_B;
            base = 4;
            n = FRAME_LEN;
        end else begin
            base = 2;
            n = BLOCK_LEN;
        end
        pkt[base]     = csum[7:0];
        pkt[base + 1] = csum[15:8];
        for (int k = 0; k < 5; k++) begin
            pkt[base + 2 + 2 * k] = vals[k][7:0];
            pkt[base + 3 + 2 * k] = vals[k][15:8];
        end
        if (corrupt) begin
            pos = $urandom_range(0, n - 1);
            pkt[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < n; i++) push_byte(pkt[i]);
    endtask

    function automatic bit [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic run_frame();
        int unsigned nblk;
        if ($urandom_range(0, 6) != 0)
            send_packet(1'b1, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                        $urandom_range(0, 9) == 0);
        nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
        for (int b = 0; b < nblk; b++) begin
            send_packet(1'b0, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                        $urandom_range(0, 11) == 0);
            repeat ($urandom_range(0, 2)) read_blob(4'($urandom_range(0, 15)));
            if ($urandom_range(0, 9) == 0) push_byte(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) read_blob(4'($urandom_range(0, 15)));
    endtask

    initial begin
        int unsigned target;
        bit          hold_done;
        bit          drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_PUSH;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty banks, stray byte, broken sync, one block, bank closed by a bad byte
        read_blob(4'd0);
        read_blob(4'd15);
        push_byte(8'hFF);
        push_byte(SYNC_A);
        push_byte(8'h00);
        send_packet(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        read_blob(4'd0);
        push_byte(SYNC_B);
        read_blob(4'd0);
        read_blob(4'd1);
        wait_results_drained();

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            if (!hold_done && words_sent + 450 > target) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && words_sent + 250 > target) begin
                wait_results_drained();
                drain_done = 1'b1;
            end
            run_frame();
        end

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
